/* rtl/core/srw_pkg.sv */
`timescale 1ns / 1ps

package srw_pkg;

  // Store geometry
  localparam int unsigned STORE_DEPTH  = 4096;
  localparam int unsigned ADDR_W       = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W        = ADDR_W + 1;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned MIN_CAPACITY = 2048;

  // APB configuration port
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic        REG_RING_CAPACITY = 1'b0;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = CNT_W'(4096);

  // Operation codes
  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_SENT   = 2'd1;
  localparam logic [OP_W-1:0] OP_ACK    = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Request into the byte store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/core/srw_in_if.sv */
`timescale 1ns / 1ps

interface srw_in_if import srw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [BYTE_W-1:0]   data_byte;
  logic [CNT_W-1:0]    byte_count;
  logic [ADDR_W-1:0]   read_offset;

  modport source (output valid, op, data_byte, byte_count, read_offset, input ready);
  modport sink   (input valid, op, data_byte, byte_count, read_offset, output ready);
endinterface

/* rtl/core/srw_out_if.sv */
`timescale 1ns / 1ps

interface srw_out_if import srw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BYTE_W-1:0]   read_byte;
  logic [CNT_W-1:0]    stored_count;
  logic [CNT_W-1:0]    unacked_count;
  logic [CNT_W-1:0]    free_count;

  modport source (output valid, status, read_byte, stored_count, unacked_count, free_count,
                  input ready);
  modport sink   (input valid, status, read_byte, stored_count, unacked_count, free_count,
                  output ready);
endinterface

/* rtl/core/srw_ring_mem.sv */
`timescale 1ns / 1ps

module srw_ring_mem import srw_pkg::*; (
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [STORE_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/send_ring_with_ack_window.sv */
`timescale 1ns / 1ps

// Send ring with acknowledge window.
// A circular byte store for a transport sender. Each input beat on in_i is one
// operation: append a byte, mark bytes as sent, acknowledge (free) bytes from
// the front, or read one unsent byte at an offset. Each input beat yields one
// result beat on out_o with a status code, the read byte and the stored,
// unacked and free counts after the operation.
// The result is registered and presented in the cycle after its input beat is taken.
// Throughput: one beat per cycle while out_o is ready; the counters are
// updated in the accepting cycle and the byte store (one write port, one
// registered read port) is accessed in the same cycle, so back-to-back
// append and read work. When out_o stalls, the result register holds its
// beat and in_i stays ready only if that beat leaves in the same cycle.
// Reset clears the pointers and counts and sets ring_capacity to 4096; store
// contents are not cleared and are never read before being written.
// ring_capacity (APB address 0) is taken only while the store is empty; a
// taken write also clears the pointers and counts. Values below 2048 act
// as 2048.
module send_ring_with_ack_window import srw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  srw_in_if.sink                in_i,
  srw_out_if.source             out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    stored;
    logic [CNT_W-1:0]    unacked;
    logic [CNT_W-1:0]    free;
    logic                rd_sel;
  } res_t;

  logic [CNT_W-1:0]  cap_q;
  logic [ADDR_W-1:0] front_q, front_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [CNT_W-1:0]  inflight_q, inflight_d;
  logic              out_valid_q;
  res_t              res_q, res_d;
  mem_req_t          mem_req;
  logic [BYTE_W-1:0] mem_rdata;

  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  unsent;
  logic              in_take;
  logic              cfg_wr;
  logic              cfg_take;

  // Reduce a sum known to lie below twice the capacity into the ring
  function automatic logic [ADDR_W-1:0] wrap(input logic [CNT_W-1:0] s,
                                             input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (s >= c) ? (s - c) : s;
    return r[ADDR_W-1:0];
  endfunction

  // APB port
  assign pready   = 1'b1;
  assign prdata   = {{(APB_DATA_W-CNT_W){1'b0}}, cap_q};
  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_RING_CAPACITY);
  assign cfg_take = cfg_wr && (held_q == '0);

  // Capacity clamped to the usable range
  always_comb begin
    if (cap_q < CNT_W'(MIN_CAPACITY)) begin
      cap_eff = CNT_W'(MIN_CAPACITY);
    end else if (cap_q > CNT_W'(STORE_DEPTH)) begin
      cap_eff = CNT_W'(STORE_DEPTH);
    end else begin
      cap_eff = cap_q;
    end
  end

  // Handshake: free slot or the held beat leaves now
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_take    = in_i.valid && in_i.ready;
  assign unsent     = held_q - inflight_q;

  // Operation decode
  always_comb begin
    front_d    = front_q;
    held_d     = held_q;
    inflight_d = inflight_q;
    res_d      = '0;
    mem_req    = '0;
    mem_req.wdata = in_i.data_byte;
    mem_req.waddr = wrap(CNT_W'(front_q) + held_q, cap_eff);
    mem_req.raddr = wrap(CNT_W'(front_q) + inflight_q + CNT_W'(in_i.read_offset), cap_eff);
    res_d.status  = ST_DONE;

    case (in_i.op)
      OP_APPEND: begin
        if (held_q >= cap_eff) begin
          res_d.status = ST_FULL;
        end else begin
          mem_req.we = in_take;
          held_d     = held_q + CNT_W'(1);
        end
      end
      OP_SENT: begin
        if (in_i.byte_count > unsent) begin
          res_d.status = ST_RANGE;
        end else begin
          inflight_d = inflight_q + in_i.byte_count;
        end
      end
      OP_ACK: begin
        if (in_i.byte_count > inflight_q) begin
          res_d.status = ST_RANGE;
        end else begin
          inflight_d = inflight_q - in_i.byte_count;
          held_d     = held_q - in_i.byte_count;
          front_d    = (held_d == '0) ? '0
                                      : wrap(CNT_W'(front_q) + in_i.byte_count, cap_eff);
        end
      end
      OP_READ: begin
        if (CNT_W'(in_i.read_offset) >= unsent) begin
          res_d.status = ST_RANGE;
        end else begin
          mem_req.re   = in_take;
          res_d.rd_sel = 1'b1;
        end
      end
      default: begin
        res_d.status = ST_RANGE;
      end
    endcase

    res_d.stored  = held_d;
    res_d.unacked = inflight_d;
    res_d.free    = cap_eff - held_d;
  end

  // Ring state and capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CAPACITY_RESET;
      front_q    <= '0;
      held_q     <= '0;
      inflight_q <= '0;
    end else if (cfg_take) begin
      cap_q      <= pwdata[CNT_W-1:0];
      front_q    <= '0;
      held_q     <= '0;
      inflight_q <= '0;
    end else if (in_take) begin
      front_q    <= front_d;
      held_q     <= held_d;
      inflight_q <= inflight_d;
    end
  end

  // Result register: valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      res_q <= res_d;
    end
  end

  srw_ring_mem u_ring_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // Output beat
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = res_q.status;
  assign out_o.read_byte     = res_q.rd_sel ? mem_rdata : '0;
  assign out_o.stored_count  = res_q.stored;
  assign out_o.unacked_count = res_q.unacked;
  assign out_o.free_count    = res_q.free;

  // Checks
  a_inflight_le_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= held_q)
    else $error("unacked count exceeds stored count");

  a_held_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= cap_eff)
    else $error("stored count exceeds capacity");

  a_empty_front_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0) |-> (front_q == '0))
    else $error("front pointer not zero on empty store");

  a_append_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && !cfg_take && (in_i.op == OP_APPEND) && (res_d.status == ST_DONE))
    |=> (held_q == $past(held_q) + CNT_W'(1)))
    else $error("append did not grow the stored count");

  a_read_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.re |-> (in_take && (in_i.op == OP_READ) && !mem_req.we))
    else $error("store read outside an accepted read");

endmodule
